### rtl/core/hpft_pkg.sv
// ----------------------------------------------------------------------------
// hpft_pkg
// shared widths, part codes and prefix tables for the hpack field tokenizer
// ----------------------------------------------------------------------------
package hpft_pkg;

    // width of the integer accumulator and string counter (16 to 64)
    localparam int VALUE_BITS = 32;

    // width of the result ports for integers and counts
    localparam int OUT_W = 32;

    // a continuation byte adds 7 bits at shift up to 28
    localparam int ADD_W = 35;
    localparam int SUM_W = ((VALUE_BITS > ADD_W) ? VALUE_BITS : ADD_W) + 1;

    localparam logic [5:0] SHIFT_CAP  = 6'd35;
    localparam logic [5:0] SHIFT_STEP = 6'd7;

    // part codes as they appear on the result port
    localparam logic [2:0] PART_IDX      = 3'd0;
    localparam logic [2:0] PART_NAME_LEN = 3'd1;
    localparam logic [2:0] PART_VAL_LEN  = 3'd2;
    localparam logic [2:0] PART_NAME     = 3'd3;
    localparam logic [2:0] PART_VAL      = 3'd4;

    // representation codes
    localparam logic [1:0] REP_INDEXED     = 2'd0;
    localparam logic [1:0] REP_INCREMENTAL = 2'd1;
    localparam logic [1:0] REP_SIZE_UPDATE = 2'd2;
    localparam logic [1:0] REP_NOT_INDEXED = 2'd3;

    // integer prefix widths
    localparam logic [2:0] PFX_4 = 3'd4;
    localparam logic [2:0] PFX_5 = 3'd5;
    localparam logic [2:0] PFX_6 = 3'd6;
    localparam logic [2:0] PFX_7 = 3'd7;

    // prefix width selected by the top nibble of a field's first byte
    function automatic logic [2:0] prefix_of_nibble(input logic [3:0] nib);
        logic [2:0] p;
        case (nib)
            4'd0, 4'd1:             p = PFX_4;
            4'd2, 4'd3:             p = PFX_5;
            4'd4, 4'd5, 4'd6, 4'd7: p = PFX_6;
            default:                p = PFX_7;
        endcase
        return p;
    endfunction

    function automatic logic [1:0] rep_of_prefix(input logic [2:0] p);
        logic [1:0] r;
        case (p)
            PFX_7:   r = REP_INDEXED;
            PFX_6:   r = REP_INCREMENTAL;
            PFX_5:   r = REP_SIZE_UPDATE;
            default: r = REP_NOT_INDEXED;
        endcase
        return r;
    endfunction

    // low-bit mask of a prefix width
    function automatic logic [7:0] prefix_mask(input logic [2:0] p);
        logic [7:0] m;
        case (p)
            3'd0:    m = 8'h00;
            3'd1:    m = 8'h01;
            3'd2:    m = 8'h03;
            3'd3:    m = 8'h07;
            3'd4:    m = 8'h0f;
            3'd5:    m = 8'h1f;
            3'd6:    m = 8'h3f;
            default: m = 8'h7f;
        endcase
        return m;
    endfunction

endpackage

### rtl/core/hpack_field_tokenizer_core.sv
// ----------------------------------------------------------------------------
// hpack_field_tokenizer_core
// byte-serial hpack header block tokenizer: classifies each byte as index,
// name length, value length, name byte or value byte and decodes the
// prefix integers with continuation
// ----------------------------------------------------------------------------
//
//  channel  dir  handshake          payload
//  -------  ---  -----------------  ---------------------------------------
//  s_       in   s_valid/s_ready    byte_in, block_start
//  m_       out  m_valid/m_ready    part, representation, int_value,
//                                   int_done, huffman, new_name,
//                                   string_left, int_overflow
//
//  one item in, one item out; an accepted item is registered and shows on m_ in the next cycle
//  sustained rate is one item per cycle while m_ready is high, set by the
//  parse-state registers, which are read and rewritten for every byte
//  s_ready is high while the result register is empty or being taken
//  aresetn is synchronous and active low; it clears the parse state and
//  drops any result not yet taken
//
module hpack_field_tokenizer_core
    import hpft_pkg::*;
(
    input  logic                 aclk,
    input  logic                 aresetn,

    input  logic                 s_valid,
    output logic                 s_ready,
    input  logic [7:0]           s_byte_in,
    input  logic                 s_block_start,

    output logic                 m_valid,
    input  logic                 m_ready,
    output logic [2:0]           m_part,
    output logic [1:0]           m_representation,
    output logic [OUT_W-1:0]     m_int_value,
    output logic                 m_int_done,
    output logic                 m_huffman,
    output logic                 m_new_name,
    output logic [OUT_W-1:0]     m_string_left,
    output logic                 m_int_overflow
);

    localparam logic [VALUE_BITS-1:0] VMAX = '1;

    // parse state
    logic [2:0]            part_reg,      part_next;
    logic [2:0]            prefix_reg,    prefix_next;
    logic [VALUE_BITS-1:0] acc_reg,       acc_next;
    logic [5:0]            shift_reg,     shift_next;
    logic [VALUE_BITS-1:0] remaining_reg, remaining_next;
    logic                  huff_reg,      huff_next;
    logic                  ovf_reg,       ovf_next;
    logic [1:0]            rep_reg,       rep_next;
    logic                  name_reg,      name_next;

    // result register
    logic                  m_valid_reg,   m_valid_next;
    logic [2:0]            part_out_reg;
    logic [1:0]            rep_out_reg;
    logic [OUT_W-1:0]      int_out_reg,   int_out_next;
    logic                  done_out_reg,  done_out_next;
    logic                  huff_out_reg;
    logic                  name_out_reg;
    logic [OUT_W-1:0]      left_out_reg,  left_out_next;
    logic                  ovf_out_reg;

    // state seen by this item: block start behaves as a reset first
    logic [2:0]            cur_part;
    logic [2:0]            cur_prefix;
    logic [VALUE_BITS-1:0] cur_acc;
    logic [5:0]            cur_shift;
    logic [VALUE_BITS-1:0] cur_remaining;
    logic                  cur_huff;
    logic                  cur_ovf;
    logic [1:0]            cur_rep;
    logic                  cur_name;

    logic                  accept;
    logic                  literal;
    logic [2:0]            eff_part;
    logic [SUM_W-1:0]      add_val;
    logic [SUM_W-1:0]      sum;
    logic [7:0]            mask;
    logic [7:0]            low_bits;
    logic                  is_str;
    logic [64:0]           acc_wide;
    logic [64:0]           rem_wide;

    assign s_ready = !m_valid_reg || m_ready;
    assign accept  = s_valid && s_ready;

    always_comb begin
        cur_part      = s_block_start ? PART_IDX : part_reg;
        cur_prefix    = s_block_start ? 3'd0 : prefix_reg;
        cur_acc       = s_block_start ? '0 : acc_reg;
        cur_shift     = s_block_start ? 6'd0 : shift_reg;
        cur_remaining = s_block_start ? '0 : remaining_reg;
        cur_huff      = s_block_start ? 1'b0 : huff_reg;
        cur_ovf       = s_block_start ? 1'b0 : ovf_reg;
        cur_rep       = s_block_start ? REP_INDEXED : rep_reg;
        cur_name      = s_block_start ? 1'b0 : name_reg;
    end

    // continuation add: 7 payload bits at the current shift
    assign add_val = SUM_W'(s_byte_in[6:0]) << cur_shift;
    assign sum     = SUM_W'(cur_acc) + add_val;

    always_comb begin
        part_next      = cur_part;
        prefix_next    = cur_prefix;
        acc_next       = cur_acc;
        shift_next     = cur_shift;
        remaining_next = cur_remaining;
        huff_next      = cur_huff;
        ovf_next       = cur_ovf;
        rep_next       = cur_rep;
        name_next      = cur_name;
        literal        = cur_prefix inside {PFX_4, PFX_6};
        eff_part       = cur_part;
        mask           = 8'h00;
        low_bits       = 8'h00;

        if (cur_remaining != '0) begin
            if (cur_part > PART_VAL_LEN) begin
                // string byte
                remaining_next = cur_remaining - VALUE_BITS'(1);
            end else begin
                // integer continuation byte
                if (!cur_ovf) begin
                    if (cur_shift >= SHIFT_CAP) begin
                        ovf_next = 1'b1;
                    end else if (sum[SUM_W-1:VALUE_BITS] != '0) begin
                        ovf_next = 1'b1;
                    end else begin
                        acc_next = sum[VALUE_BITS-1:0];
                    end
                    if (ovf_next) begin
                        acc_next = VMAX;
                    end
                end
                shift_next = (cur_shift >= SHIFT_CAP - SHIFT_STEP) ?
                             SHIFT_CAP : cur_shift + SHIFT_STEP;
                remaining_next = VALUE_BITS'(s_byte_in[7]);
            end
        end else begin
            // first byte of a new part; an empty string is skipped over
            if ((cur_part == PART_NAME_LEN || cur_part == PART_VAL_LEN) &&
                cur_acc == '0) begin
                eff_part = cur_part + 3'd2;
            end

            if (eff_part == PART_NAME_LEN || eff_part == PART_VAL_LEN) begin
                part_next      = eff_part + 3'd2;
                remaining_next = cur_acc - VALUE_BITS'(1);
                prefix_next    = 3'd0;
            end else if (eff_part == PART_IDX && cur_acc == '0 && literal) begin
                part_next      = PART_NAME_LEN;
                remaining_next = '0;
                prefix_next    = PFX_7;
                name_next      = 1'b1;
            end else if ((eff_part == PART_IDX && literal) || eff_part == PART_NAME) begin
                part_next      = PART_VAL_LEN;
                remaining_next = '0;
                prefix_next    = PFX_7;
            end else begin
                // new field: representation from the top nibble
                part_next      = PART_IDX;
                remaining_next = '0;
                prefix_next    = prefix_of_nibble(s_byte_in[7:4]);
                rep_next       = rep_of_prefix(prefix_next);
                name_next      = 1'b0;
            end
            acc_next   = '0;
            shift_next = 6'd0;

            if (part_next <= PART_VAL_LEN) begin
                mask           = prefix_mask(prefix_next);
                low_bits       = s_byte_in & mask;
                acc_next       = VALUE_BITS'(low_bits);
                remaining_next = VALUE_BITS'(low_bits == mask);
                huff_next      = s_byte_in[7];
                ovf_next       = 1'b0;
            end
        end
    end

    // result fields, taken from the updated state
    assign is_str        = part_next > PART_VAL_LEN;
    assign acc_wide      = 65'(acc_next);
    assign rem_wide      = 65'(remaining_next);
    assign int_out_next  = is_str ? '0 : acc_wide[OUT_W-1:0];
    assign left_out_next = is_str ? rem_wide[OUT_W-1:0] : '0;
    assign done_out_next = !is_str && (remaining_next == '0);

    always_comb begin
        m_valid_next = m_valid_reg;
        if (accept) begin
            m_valid_next = 1'b1;
        end else if (m_ready) begin
            m_valid_next = 1'b0;
        end
    end

    // control and parse state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg   <= 1'b0;
            part_reg      <= PART_IDX;
            prefix_reg    <= 3'd0;
            acc_reg       <= '0;
            shift_reg     <= 6'd0;
            remaining_reg <= '0;
            huff_reg      <= 1'b0;
            ovf_reg       <= 1'b0;
            rep_reg       <= REP_INDEXED;
            name_reg      <= 1'b0;
        end else begin
            m_valid_reg <= m_valid_next;
            if (accept) begin
                part_reg      <= part_next;
                prefix_reg    <= prefix_next;
                acc_reg       <= acc_next;
                shift_reg     <= shift_next;
                remaining_reg <= remaining_next;
                huff_reg      <= huff_next;
                ovf_reg       <= ovf_next;
                rep_reg       <= rep_next;
                name_reg      <= name_next;
            end
        end
    end

    // result payload, loaded only on accept
    always_ff @(posedge aclk) begin
        if (accept) begin
            part_out_reg <= part_next;
            rep_out_reg  <= rep_next;
            int_out_reg  <= int_out_next;
            done_out_reg <= done_out_next;
            huff_out_reg <= huff_next;
            name_out_reg <= name_next;
            left_out_reg <= left_out_next;
            ovf_out_reg  <= ovf_next;
        end
    end

    assign m_valid          = m_valid_reg;
    assign m_part           = part_out_reg;
    assign m_representation = rep_out_reg;
    assign m_int_value      = int_out_reg;
    assign m_int_done       = done_out_reg;
    assign m_huffman        = huff_out_reg;
    assign m_new_name       = name_out_reg;
    assign m_string_left    = left_out_reg;
    assign m_int_overflow   = ovf_out_reg;

    // a held result blocks the input side
    a_stall_blocks_input: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |-> !s_ready)
        else $error("input accepted while result stalled");

    // string bytes never report a finished integer or an integer value
    a_string_no_int: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_part > PART_VAL_LEN |-> !m_int_done && m_int_value == '0)
        else $error("string byte carries integer fields");

    // integer bytes carry no string count
    a_int_no_left: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_part <= PART_VAL_LEN |-> m_string_left == '0)
        else $error("integer byte carries a string count");

    // the part register only holds the five defined codes
    a_part_range: assert property (@(posedge aclk) disable iff (!aresetn)
        part_reg <= PART_VAL)
        else $error("part register out of range");

endmodule

### bench/tb_hpack_field_tokenizer_core.sv
// ----------------------------------------------------------------------------
// tb_hpack_field_tokenizer_core
// self-checking bench for the byte-serial hpack field tokenizer: a directed
// table of header bytes, then well-formed header blocks with random content
// mixed with noise and cut-off fields. every byte's token is predicted in the
// bench and compared field by field with the token the block returns, under
// several patterns of sender idling and receiver stalls.
// ----------------------------------------------------------------------------
module tb_hpack_field_tokenizer_core
    import hpft_pkg::*;
();

    timeunit 1ns;
    timeprecision 1ps;

    // one token per byte, as it appears on the m_ ports
    typedef struct packed {
        logic [2:0]       part;
        logic [1:0]       representation;
        logic [OUT_W-1:0] int_value;
        logic             int_done;
        logic             huffman;
        logic             new_name;
        logic [OUT_W-1:0] string_left;
        logic             int_overflow;
    } tok_result_t;

    // one byte of stimulus; typed rows carry a hand-written token
    typedef struct packed {
        logic [7:0]  data;
        logic        blk;
        logic        typed;
        tok_result_t want;
    } stim_row_t;

    // largest integer the accumulator holds
    localparam logic [63:0] VAL_MAX = (64'd1 << VALUE_BITS) - 64'd1;

    // random part length and idle time limit
    localparam int N_RANDOM   = 1600;
    localparam int IDLE_LIMIT = 2000;

    logic             aclk = 1'b0;
    logic             aresetn;
    logic             s_valid;
    logic             s_ready;
    logic [7:0]       s_byte_in;
    logic             s_block_start;
    logic             m_valid;
    logic             m_ready;
    logic [2:0]       m_part;
    logic [1:0]       m_representation;
    logic [OUT_W-1:0] m_int_value;
    logic             m_int_done;
    logic             m_huffman;
    logic             m_new_name;
    logic [OUT_W-1:0] m_string_left;
    logic             m_int_overflow;

    // tokens still to come back, oldest first
    tok_result_t pending_tokens[$];
    // bytes of the random part, built before they are sent
    stim_row_t   feed_q[$];
    // next generated byte opens a new header block
    logic        start_blk;

    int errors;
    int idle_cycles;
    int src_idle_pct;
    int snk_stall_pct;

    // parser state of the predictor
    logic [2:0]  tk_part;
    logic [2:0]  tk_pfx;
    logic [63:0] tk_acc;
    logic [5:0]  tk_shift;
    logic [63:0] tk_left;
    logic        tk_huff;
    logic        tk_ovf;
    logic [1:0]  tk_rep;
    logic        tk_name;

    hpack_field_tokenizer_core u_top (
        .aclk             (aclk),
        .aresetn          (aresetn),
        .s_valid          (s_valid),
        .s_ready          (s_ready),
        .s_byte_in        (s_byte_in),
        .s_block_start    (s_block_start),
        .m_valid          (m_valid),
        .m_ready          (m_ready),
        .m_part           (m_part),
        .m_representation (m_representation),
        .m_int_value      (m_int_value),
        .m_int_done       (m_int_done),
        .m_huffman        (m_huffman),
        .m_new_name       (m_new_name),
        .m_string_left    (m_string_left),
        .m_int_overflow   (m_int_overflow)
    );

    // 10 ns clock
    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    // ------------------------------------------------------------------
    // token predictor
    // ------------------------------------------------------------------

    function automatic void clear_parser();
        tk_part  = PART_IDX;
        tk_pfx   = '0;
        tk_acc   = '0;
        tk_shift = '0;
        tk_left  = '0;
        tk_huff  = 1'b0;
        tk_ovf   = 1'b0;
        tk_rep   = REP_INDEXED;
        tk_name  = 1'b0;
    endfunction

    // advance the parser by one byte and return the token it produces
    function automatic tok_result_t tokenize_byte(input logic [7:0] c, input logic blk);
        tok_result_t r;
        logic [2:0]  p;
        logic        lit;
        logic        is_str;
        logic [63:0] fmask;
        logic [63:0] add;
        logic [63:0] sum;
        if (blk)
            clear_parser();
        if (tk_left != 0) begin
            if (tk_part > PART_VAL_LEN) begin
                // inside a string: count down
                tk_left = tk_left - 64'd1;
            end else begin
                // continuation byte of a prefix integer
                if (!tk_ovf) begin
                    if (tk_shift >= SHIFT_CAP) begin
                        tk_ovf = 1'b1;
                    end else begin
                        add = 64'(c[6:0]) << tk_shift;
                        sum = tk_acc + add;
                        if (sum < tk_acc || sum > VAL_MAX)
                            tk_ovf = 1'b1;
                        else
                            tk_acc = sum;
                    end
                    if (tk_ovf)
                        tk_acc = VAL_MAX;
                end
                tk_shift = (tk_shift + SHIFT_STEP > SHIFT_CAP) ? SHIFT_CAP
                                                               : tk_shift + SHIFT_STEP;
                tk_left  = {63'd0, c[7]};
            end
        end else begin
            // first byte of a new part
            p   = tk_part;
            lit = (tk_pfx == PFX_6) || (tk_pfx == PFX_4);
            // empty string: behave as if the string just ended
            if ((p == PART_NAME_LEN || p == PART_VAL_LEN) && tk_acc == 0)
                p = p + 3'd2;
            if (p == PART_NAME_LEN || p == PART_VAL_LEN) begin
                tk_part = p + 3'd2;
                tk_left = (tk_acc - 64'd1) & VAL_MAX;
                tk_pfx  = '0;
            end else if (p == PART_IDX && tk_acc == 0 && lit) begin
                tk_part = PART_NAME_LEN;
                tk_left = '0;
                tk_pfx  = PFX_7;
                tk_name = 1'b1;
            end else if ((p == PART_IDX && lit) || p == PART_NAME) begin
                tk_part = PART_VAL_LEN;
                tk_left = '0;
                tk_pfx  = PFX_7;
            end else begin
                tk_part = PART_IDX;
                tk_left = '0;
                tk_pfx  = c[7] ? PFX_7 : c[6] ? PFX_6 : c[5] ? PFX_5 : PFX_4;
                case (tk_pfx)
                    PFX_7:   tk_rep = REP_INDEXED;
                    PFX_6:   tk_rep = REP_INCREMENTAL;
                    PFX_5:   tk_rep = REP_SIZE_UPDATE;
                    default: tk_rep = REP_NOT_INDEXED;
                endcase
                tk_name = 1'b0;
            end
            tk_acc   = '0;
            tk_shift = '0;
            if (tk_part <= PART_VAL_LEN) begin
                fmask   = (64'd1 << tk_pfx) - 64'd1;
                tk_acc  = {56'd0, c} & fmask;
                tk_left = (tk_acc == fmask) ? 64'd1 : 64'd0;
                tk_huff = c[7];
                tk_ovf  = 1'b0;
            end
        end
        is_str           = tk_part > PART_VAL_LEN;
        r.part           = tk_part;
        r.representation = tk_rep;
        r.int_value      = is_str ? '0 : tk_acc[OUT_W-1:0];
        r.int_done       = !is_str && tk_left == 0;
        r.huffman        = tk_huff;
        r.new_name       = tk_name;
        r.string_left    = is_str ? tk_left[OUT_W-1:0] : '0;
        r.int_overflow   = tk_ovf;
        return r;
    endfunction

    // ------------------------------------------------------------------
    // header block generator
    // ------------------------------------------------------------------

    function automatic void put_byte(input logic [7:0] d);
        stim_row_t r;
        r       = '0;
        r.data  = d;
        r.blk   = start_blk;
        start_blk = 1'b0;
        feed_q.push_back(r);
    endfunction

    // hpack prefix integer; pad adds redundant zero continuation bytes
    function automatic void put_int(input logic [7:0] top, input int pbits,
                                    input logic [63:0] v, input int pad);
        logic [63:0] fmask;
        logic [63:0] rest;
        fmask = (64'd1 << pbits) - 64'd1;
        if (v < fmask) begin
            put_byte(top | v[7:0]);
        end else begin
            put_byte(top | fmask[7:0]);
            rest = v - fmask;
            while (rest >= 64'd128) begin
                put_byte({1'b1, rest[6:0]});
                rest = rest >> 7;
            end
            for (int k = 0; k < pad; k++) begin
                put_byte({1'b1, rest[6:0]});
                rest = '0;
            end
            put_byte({1'b0, rest[6:0]});
        end
    endfunction

    // random index or length; returns all ones when the value saturates
    function automatic logic [63:0] put_rand_int(input logic [7:0] top, input int pbits,
                                                 input logic is_len);
        logic [63:0] fmask;
        logic [63:0] v;
        int          sel;
        int          pad;
        fmask = (64'd1 << pbits) - 64'd1;
        sel   = $urandom_range(0, 99);
        pad   = 0;
        if (is_len) begin
            if (sel < 80)
                v = 64'($urandom_range(0, 8));
            else if (sel < 91)
                v = 64'($urandom_range(120, 200));
            else if (sel < 94)
                v = 64'($urandom) | 64'h1000;
            else if (sel < 97)
                v = {24'd0, 8'($urandom_range(1, 255)), 32'($urandom)};
            else begin
                v   = fmask + 64'($urandom_range(0, 8));
                pad = $urandom_range(1, 7);
            end
        end else begin
            if (sel < 50)
                v = 64'($urandom_range(0, 32'(fmask) - 1));
            else if (sel < 60)
                v = fmask;
            else if (sel < 75)
                v = fmask + 64'($urandom_range(0, 5000));
            else if (sel < 85)
                v = 64'($urandom);
            else if (sel < 88)
                v = VAL_MAX;
            else if (sel < 94)
                v = {24'd0, 8'($urandom_range(1, 255)), 32'($urandom)};
            else begin
                v   = fmask + 64'($urandom_range(0, 200));
                pad = $urandom_range(1, 7);
            end
        end
        put_int(top, pbits, v, pad);
        // more than five continuation bytes always saturate
        return (pad > 4 || v > VAL_MAX) ? '1 : v;
    endfunction

    // length plus string bytes; returns 1 when the string was cut off
    function automatic logic put_string();
        logic [63:0] len;
        len = put_rand_int({1'($urandom_range(0, 1)), 7'd0}, 7, 1'b1);
        if (len > 64'd300) begin
            // too long to send: a few bytes, then a fresh block
            repeat ($urandom_range(1, 4)) put_byte(8'($urandom));
            start_blk = 1'b1;
            return 1'b1;
        end
        for (int k = 0; k < int'(len); k++)
            put_byte(8'($urandom));
        return 1'b0;
    endfunction

    // one header field, or now and then noise or a field cut short
    function automatic void put_field();
        logic [63:0] idx;
        logic [7:0]  top;
        logic        cut;
        int          pbits;
        int          sel;
        int          keep;
        sel = $urandom_range(0, 99);
        if (sel < 5) begin
            // noise bytes, some opening blocks
            repeat ($urandom_range(1, 6)) begin
                start_blk = ($urandom_range(0, 3) == 0);
                put_byte(8'($urandom));
            end
            start_blk = 1'b1;
            return;
        end
        if ($urandom_range(0, 19) == 0)
            start_blk = 1'b1;
        keep = feed_q.size();
        case ($urandom_range(0, 3))
            0:       begin top = 8'h80; pbits = 7; end
            1:       begin top = 8'h40; pbits = 6; end
            2:       begin top = 8'h20; pbits = 5; end
            default: begin top = {3'b000, 1'($urandom_range(0, 1)), 4'h0}; pbits = 4; end
        endcase
        if (pbits == 6 || pbits == 4) begin
            if ($urandom_range(0, 2) == 0) begin
                idx = '0;
                put_byte(top);
            end else begin
                idx = put_rand_int(top, pbits, 1'b0);
            end
            cut = 1'b0;
            if (idx == 0)
                cut = put_string();
            if (!cut)
                void'(put_string());
        end else begin
            void'(put_rand_int(top, pbits, 1'b0));
        end
        if (sel < 10 && feed_q.size() > keep + 1) begin
            // cut the field short and restart the block
            while (feed_q.size() > keep + 1 &&
                   feed_q.size() > keep + $urandom_range(1, 4))
                void'(feed_q.pop_back());
            start_blk = 1'b1;
        end
    endfunction

    // ------------------------------------------------------------------
    // sender: one item per call, entered and left at a falling edge
    // ------------------------------------------------------------------

    task automatic send_item(input stim_row_t r);
        tok_result_t want;
        while ($urandom_range(0, 99) < src_idle_pct) begin
            s_valid <= 1'b0;
            @(negedge aclk);
        end
        s_valid       <= 1'b1;
        s_byte_in     <= r.data;
        s_block_start <= r.blk;
        @(posedge aclk);
        while (!s_ready)
            @(posedge aclk);
        // accepted on this edge
        want = tokenize_byte(r.data, r.blk);
        pending_tokens.push_back(r.typed ? r.want : want);
        @(negedge aclk);
    endtask

    function automatic stim_row_t mk_row(input logic [7:0] d, input logic blk,
                                         input logic typed, input tok_result_t w);
        stim_row_t r;
        r.data  = d;
        r.blk   = blk;
        r.typed = typed;
        r.want  = w;
        return r;
    endfunction

    // ------------------------------------------------------------------
    // receiver: random stalls at the falling edge
    // ------------------------------------------------------------------

    always @(negedge aclk) begin
        m_ready <= ($urandom_range(0, 99) >= snk_stall_pct);
    end

    task automatic report_miss(input string what, input tok_result_t want,
                               input tok_result_t got);
        errors++;
        if (errors <= 10) begin
            $display("%0t %s", $realtime, what);
            $display("  exp part=%0d rep=%0d int=%h done=%b huff=%b name=%b left=%h ovf=%b",
                     want.part, want.representation, want.int_value, want.int_done,
                     want.huffman, want.new_name, want.string_left, want.int_overflow);
            $display("  got part=%0d rep=%0d int=%h done=%b huff=%b name=%b left=%h ovf=%b",
                     got.part, got.representation, got.int_value, got.int_done,
                     got.huffman, got.new_name, got.string_left, got.int_overflow);
        end
    endtask

    // token checker, sampled on the rising edge
    always @(posedge aclk) begin
        tok_result_t got;
        tok_result_t want;
        if (aresetn === 1'b1 && m_valid && m_ready) begin
            got.part           = m_part;
            got.representation = m_representation;
            got.int_value      = m_int_value;
            got.int_done       = m_int_done;
            got.huffman        = m_huffman;
            got.new_name       = m_new_name;
            got.string_left    = m_string_left;
            got.int_overflow   = m_int_overflow;
            if (pending_tokens.size() == 0) begin
                report_miss("token with nothing expected", '0, got);
            end else begin
                want = pending_tokens.pop_front();
                if (got !== want)
                    report_miss("token mismatch", want, got);
            end
        end
    end

    // watchdog: too long with no item moving on either side
    always @(posedge aclk) begin
        if (aresetn === 1'b1) begin
            if ((s_valid && s_ready) || (m_valid && m_ready))
                idle_cycles <= 0;
            else
                idle_cycles <= idle_cycles + 1;
            if (idle_cycles >= IDLE_LIMIT) begin
                $display("watchdog: no progress for %0d cycles", IDLE_LIMIT);
                $display("DONE: errors detected");
                $finish;
            end
        end
    end

    // ------------------------------------------------------------------
    // main sequence
    // ------------------------------------------------------------------

    initial begin
        stim_row_t dir_tab[$];
        int        n_feed;
        s_valid       = 1'b0;
        s_byte_in     = '0;
        s_block_start = 1'b0;
        m_ready       = 1'b0;
        aresetn       = 1'b0;
        errors        = 0;
        idle_cycles   = 0;
        src_idle_pct  = 0;
        snk_stall_pct = 0;
        start_blk     = 1'b0;
        clear_parser();

        repeat (9) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        // indexed field, index 2
        dir_tab.push_back(mk_row(8'h82, 1'b1, 1'b1, tok_result_t'{PART_IDX, REP_INDEXED,
            32'd2, 1'b1, 1'b1, 1'b0, 32'd0, 1'b0}));
        // indexed 127 plus two continuation bytes
        dir_tab.push_back(mk_row(8'hff, 1'b0, 1'b0, '0));
        dir_tab.push_back(mk_row(8'h80, 1'b0, 1'b0, '0));
        dir_tab.push_back(mk_row(8'h01, 1'b0, 1'b0, '0));
        // incremental literal with its own name
        dir_tab.push_back(mk_row(8'h40, 1'b0, 1'b1, tok_result_t'{PART_IDX, REP_INCREMENTAL,
            32'd0, 1'b1, 1'b0, 1'b0, 32'd0, 1'b0}));
        dir_tab.push_back(mk_row(8'h83, 1'b0, 1'b1, tok_result_t'{PART_NAME_LEN,
            REP_INCREMENTAL, 32'd3, 1'b1, 1'b1, 1'b1, 32'd0, 1'b0}));
        dir_tab.push_back(mk_row(8'h00, 1'b0, 1'b0, '0));
        dir_tab.push_back(mk_row(8'hff, 1'b0, 1'b0, '0));
        dir_tab.push_back(mk_row(8'h5a, 1'b0, 1'b0, '0));
        // empty value, skipped
        dir_tab.push_back(mk_row(8'h00, 1'b0, 1'b1, tok_result_t'{PART_VAL_LEN,
            REP_INCREMENTAL, 32'd0, 1'b1, 1'b0, 1'b1, 32'd0, 1'b0}));
        // not-indexed literal whose index saturates past five continuation bytes
        dir_tab.push_back(mk_row(8'h0f, 1'b0, 1'b0, '0));
        repeat (5) dir_tab.push_back(mk_row(8'hff, 1'b0, 1'b0, '0));
        dir_tab.push_back(mk_row(8'h7f, 1'b0, 1'b1, tok_result_t'{PART_IDX, REP_NOT_INDEXED,
            32'hffff_ffff, 1'b1, 1'b0, 1'b0, 32'd0, 1'b1}));
        // two-byte value
        dir_tab.push_back(mk_row(8'h02, 1'b0, 1'b0, '0));
        dir_tab.push_back(mk_row(8'h41, 1'b0, 1'b0, '0));
        dir_tab.push_back(mk_row(8'h42, 1'b0, 1'b0, '0));
        // size update 5
        dir_tab.push_back(mk_row(8'h25, 1'b0, 1'b1, tok_result_t'{PART_IDX, REP_SIZE_UPDATE,
            32'd5, 1'b1, 1'b0, 1'b0, 32'd0, 1'b0}));
        // new block, size update left unfinished by the next block start
        dir_tab.push_back(mk_row(8'h3f, 1'b1, 1'b0, '0));
        dir_tab.push_back(mk_row(8'he1, 1'b0, 1'b0, '0));
        dir_tab.push_back(mk_row(8'h10, 1'b1, 1'b1, tok_result_t'{PART_IDX, REP_NOT_INDEXED,
            32'd0, 1'b1, 1'b0, 1'b0, 32'd0, 1'b0}));
        // empty name, then a one-byte huffman value
        dir_tab.push_back(mk_row(8'h00, 1'b0, 1'b0, '0));
        dir_tab.push_back(mk_row(8'h81, 1'b0, 1'b0, '0));
        dir_tab.push_back(mk_row(8'hc0, 1'b0, 1'b0, '0));

        foreach (dir_tab[i])
            send_item(dir_tab[i]);

        // random header blocks
        start_blk = 1'b1;
        while (feed_q.size() < N_RANDOM)
            put_field();
        n_feed = feed_q.size();

        // four idling phases over the random part
        foreach (feed_q[i]) begin
            case ((i * 4) / n_feed)
                0:       begin src_idle_pct = 0;  snk_stall_pct = 0;  end
                1:       begin src_idle_pct = 69; snk_stall_pct = 0;  end
                2:       begin src_idle_pct = 0;  snk_stall_pct = 69; end
                default: begin src_idle_pct = 32; snk_stall_pct = 32; end
            endcase
            send_item(feed_q[i]);
        end
        s_valid <= 1'b0;

        // drain, then a few cycles for anything unexpected
        while (pending_tokens.size() != 0)
            @(posedge aclk);
        repeat (10) @(posedge aclk);
        errors += pending_tokens.size();

        if (errors == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end

endmodule
